>>> rtl/quaternion_to_rotation_matrix_defines.svh
// Assertion macros for the quaternion to rotation matrix block
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

// same-cycle implication, off during reset
`define QRM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, off during reset
`define QRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

>>> rtl/qrm_pkg.sv
// Shared constants, types and rounding functions for the quaternion to matrix block
`default_nettype none
package qrm_pkg;

   localparam int FRAC_BITS  = 14;
   localparam int COMP_WIDTH = 16;

   localparam int PROD_W  = 2 * COMP_WIDTH;
   localparam int NORM_W  = 2 * COMP_WIDTH + 1;
   localparam int NUM_W   = NORM_W + 1;
   localparam int REM_W   = NORM_W + 1;
   localparam int QUO_W   = FRAC_BITS + 2;
   localparam int EXT_W   = ((QUO_W + 1 > COMP_WIDTH) ? QUO_W + 1 : COMP_WIDTH) + 1;
   localparam int LATENCY = QUO_W + 3;
   localparam int ENTRIES = 9;

   typedef struct packed {
      logic              neg;
      logic [NORM_W-1:0] mag;
   } num_type;

   function automatic logic signed [COMP_WIDTH-1:0] sat_val(input logic signed [EXT_W-1:0] v);
      logic signed [EXT_W-1:0] hi;
      logic signed [EXT_W-1:0] lo;
      hi = EXT_W'({1'b0, {(COMP_WIDTH-1){1'b1}}});
      lo = -hi - EXT_W'(1);
      if (v > hi) begin
         return hi[COMP_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[COMP_WIDTH-1:0];
      end
      return v[COMP_WIDTH-1:0];
   endfunction

   // half-LSB rounding away from zero, sign applied after
   function automatic logic signed [COMP_WIDTH-1:0] round_entry(input logic neg,
                                                                input logic [QUO_W-1:0] q);
      logic [QUO_W:0]          qp;
      logic signed [EXT_W-1:0] v;
      qp = {1'b0, q} + {{QUO_W{1'b0}}, 1'b1};
      v  = signed'(EXT_W'(qp[QUO_W:1]));
      if (neg) begin
         v = -v;
      end
      return sat_val(v);
   endfunction

   localparam logic signed [COMP_WIDTH-1:0] ONE_ENTRY = sat_val(EXT_W'(1) <<< FRAC_BITS);

endpackage
`default_nettype wire

>>> rtl/qrm_div_lane.sv
// Pipelined restoring divider lane, one quotient bit per stage
`default_nettype none
module qrm_div_lane
   import qrm_pkg::*;
(
   input  wire logic              clock,
   input  wire num_type           num_in,
   input  wire logic [NORM_W-1:0] den_in,
   output logic                   neg_out,
   output logic [QUO_W-1:0]       quo_out
);

   logic [REM_W-1:0]  rem_ff [0:QUO_W];
   logic [NORM_W-1:0] den_ff [0:QUO_W];
   logic [QUO_W-1:0]  quo_ff [0:QUO_W];
   logic              neg_ff [0:QUO_W];

   always_ff @(posedge clock) begin
      rem_ff[0] <= REM_W'(num_in.mag);
      den_ff[0] <= den_in;
      quo_ff[0] <= '0;
      neg_ff[0] <= num_in.neg;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic             ge;
      logic [REM_W-1:0] rem_in;
      always_comb begin
         ge     = rem_ff[k] >= REM_W'(den_ff[k]);
         rem_in = ge ? rem_ff[k] - REM_W'(den_ff[k]) : rem_ff[k];
      end
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= {rem_in[REM_W-2:0], 1'b0};
         den_ff[k+1] <= den_ff[k];
         quo_ff[k+1] <= {quo_ff[k][QUO_W-2:0], ge};
         neg_ff[k+1] <= neg_ff[k];
      end
   end

   assign neg_out = neg_ff[QUO_W];
   assign quo_out = quo_ff[QUO_W];

endmodule
`default_nettype wire

>>> rtl/quaternion_to_rotation_matrix.sv
// Top level: quaternion to 3x3 rotation matrix, fully pipelined
`default_nettype none
`include "quaternion_to_rotation_matrix_defines.svh"
// Takes one quaternion per cycle (busy is always low) and returns its normalised rotation
// matrix as a one-cycle word on rsp_valid; the receiver cannot stall and need not. Latency
// is set by the nine 16-stage divider lanes (one quotient bit per stage) plus product,
// numerator and rounding stages. A zero quaternion gives the identity and rsp_zero_error.
// csr_wdata selects row order (0) or transposed order (1); write it idle.
module quaternion_to_rotation_matrix
   import qrm_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [COMP_WIDTH-1:0] req_qw,
   input  wire logic signed [COMP_WIDTH-1:0] req_qx,
   input  wire logic signed [COMP_WIDTH-1:0] req_qy,
   input  wire logic signed [COMP_WIDTH-1:0] req_qz,
   input  wire logic                         csr_we,
   input  wire logic                         csr_wdata,
   output logic                              rsp_valid,
   output logic signed [COMP_WIDTH-1:0]      rsp_m00,
   output logic signed [COMP_WIDTH-1:0]      rsp_m01,
   output logic signed [COMP_WIDTH-1:0]      rsp_m02,
   output logic signed [COMP_WIDTH-1:0]      rsp_m10,
   output logic signed [COMP_WIDTH-1:0]      rsp_m11,
   output logic signed [COMP_WIDTH-1:0]      rsp_m12,
   output logic signed [COMP_WIDTH-1:0]      rsp_m20,
   output logic signed [COMP_WIDTH-1:0]      rsp_m21,
   output logic signed [COMP_WIDTH-1:0]      rsp_m22,
   output logic                              rsp_zero_error
);

   logic                     transpose_ff;
   logic                     v_ff [0:QUO_W+2];
   logic                     zero_ff [0:QUO_W];
   logic signed [PROD_W-1:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, xw_ff, yz_ff, yw_ff, zw_ff;
   logic signed [NUM_W-1:0]  sum_in [0:ENTRIES-1];
   num_type                  num_in [0:ENTRIES-1];
   logic [NORM_W-1:0]        norm_in;
   logic                     lane_neg [0:ENTRIES-1];
   logic [QUO_W-1:0]         lane_quo [0:ENTRIES-1];
   logic signed [COMP_WIDTH-1:0] ent [0:ENTRIES-1];
   logic signed [COMP_WIDTH-1:0] m_in [0:ENTRIES-1];
   logic signed [COMP_WIDTH-1:0] m_ff [0:ENTRIES-1];
   logic                     err_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         transpose_ff <= 1'b0;
      end else if (csr_we) begin
         transpose_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUO_W + 2; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         v_ff[0] <= start && !busy;
         for (int k = 1; k <= QUO_W + 2; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      ww_ff <= req_qw * req_qw;
      xx_ff <= req_qx * req_qx;
      yy_ff <= req_qy * req_qy;
      zz_ff <= req_qz * req_qz;
      xy_ff <= req_qx * req_qy;
      xz_ff <= req_qx * req_qz;
      xw_ff <= req_qx * req_qw;
      yz_ff <= req_qy * req_qz;
      yw_ff <= req_qy * req_qw;
      zw_ff <= req_qz * req_qw;
   end

   always_comb begin
      norm_in = NORM_W'(ww_ff) + NORM_W'(xx_ff) + NORM_W'(yy_ff) + NORM_W'(zz_ff);
      sum_in[0] = NUM_W'(ww_ff) + NUM_W'(xx_ff) - NUM_W'(yy_ff) - NUM_W'(zz_ff);
      sum_in[1] = (NUM_W'(xy_ff) - NUM_W'(zw_ff)) <<< 1;
      sum_in[2] = (NUM_W'(xz_ff) + NUM_W'(yw_ff)) <<< 1;
      sum_in[3] = (NUM_W'(xy_ff) + NUM_W'(zw_ff)) <<< 1;
      sum_in[4] = NUM_W'(ww_ff) - NUM_W'(xx_ff) + NUM_W'(yy_ff) - NUM_W'(zz_ff);
      sum_in[5] = (NUM_W'(yz_ff) - NUM_W'(xw_ff)) <<< 1;
      sum_in[6] = (NUM_W'(xz_ff) - NUM_W'(yw_ff)) <<< 1;
      sum_in[7] = (NUM_W'(yz_ff) + NUM_W'(xw_ff)) <<< 1;
      sum_in[8] = NUM_W'(ww_ff) - NUM_W'(xx_ff) - NUM_W'(yy_ff) + NUM_W'(zz_ff);
      for (int e = 0; e < ENTRIES; e++) begin
         num_in[e].neg = sum_in[e][NUM_W-1];
         num_in[e].mag = sum_in[e][NUM_W-1] ? NORM_W'(-sum_in[e]) : NORM_W'(sum_in[e]);
      end
   end

   for (genvar e = 0; e < ENTRIES; e++) begin : g_lane
      qrm_div_lane u_lane (
         .clock   (clock),
         .num_in  (num_in[e]),
         .den_in  (norm_in),
         .neg_out (lane_neg[e]),
         .quo_out (lane_quo[e])
      );
   end

   always_ff @(posedge clock) begin
      zero_ff[0] <= norm_in == '0;
      for (int k = 1; k <= QUO_W; k++) begin
         zero_ff[k] <= zero_ff[k-1];
      end
   end

   always_comb begin
      for (int e = 0; e < ENTRIES; e++) begin
         ent[e] = round_entry(lane_neg[e], lane_quo[e]);
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (zero_ff[QUO_W]) begin
               m_in[r*3+c] = (r == c) ? ONE_ENTRY : '0;
            end else if (transpose_ff) begin
               m_in[r*3+c] = ent[c*3+r];
            end else begin
               m_in[r*3+c] = ent[r*3+c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < ENTRIES; e++) begin
         m_ff[e] <= m_in[e];
      end
      err_ff <= zero_ff[QUO_W];
   end

   assign rsp_valid      = v_ff[QUO_W+2];
   assign rsp_zero_error = err_ff;
   assign rsp_m00        = m_ff[0];
   assign rsp_m01        = m_ff[1];
   assign rsp_m02        = m_ff[2];
   assign rsp_m10        = m_ff[3];
   assign rsp_m11        = m_ff[4];
   assign rsp_m12        = m_ff[5];
   assign rsp_m20        = m_ff[6];
   assign rsp_m21        = m_ff[7];
   assign rsp_m22        = m_ff[8];

   `QRM_ASSERT_NOW(a_latency, clock, reset, 1'b1, rsp_valid == $past(start && !reset, LATENCY))
   `QRM_ASSERT_NOW(a_zero_flag, clock, reset, rsp_valid, rsp_zero_error == $past(req_qw == '0 && req_qx == '0 && req_qy == '0 && req_qz == '0, LATENCY))
   `QRM_ASSERT_NOW(a_identity, clock, reset, rsp_valid && rsp_zero_error, rsp_m00 == ONE_ENTRY && rsp_m11 == ONE_ENTRY && rsp_m22 == ONE_ENTRY && rsp_m01 == '0 && rsp_m02 == '0 && rsp_m10 == '0 && rsp_m12 == '0 && rsp_m20 == '0 && rsp_m21 == '0)

endmodule
`default_nettype wire
